@@ src/pfr_pkg.sv @@
// Package for the pedal frame receiver: event codes, command bytes, the
// frame job record passed from front to back, and the button decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package pfr_pkg;

	// Command bytes that open a frame
	localparam logic [7:0] CMD_ANNOUNCE = 8'hFD;
	localparam logic [7:0] CMD_BUTTON   = 8'hFC;
	localparam logic [7:0] CMD_POS      = 8'hFB;
	localparam logic [7:0] CMD_DOUBLE   = 8'hFA;

	// Pedal ids carried by an init frame
	localparam logic [7:0] ID_FTSW = 8'h08;
	localparam logic [7:0] ID_EXP  = 8'h0C;

	// Reply bytes
	localparam logic [7:0] REPLY_ACK = 8'hFD;
	localparam logic [7:0] REPLY_ERR = 8'hFE;

	// Event codes
	localparam logic [3:0] EV_FTSW_INIT = 4'd0;
	localparam logic [3:0] EV_EXP_INIT  = 4'd1;
	localparam logic [3:0] EV_BTN1_DOWN = 4'd2;
	localparam logic [3:0] EV_BTN2_DOWN = 4'd3;
	localparam logic [3:0] EV_BTN3_DOWN = 4'd4;
	localparam logic [3:0] EV_BTN4_DOWN = 4'd5;
	localparam logic [3:0] EV_BTN1_UP   = 4'd6;
	localparam logic [3:0] EV_BTN2_UP   = 4'd7;
	localparam logic [3:0] EV_BTN3_UP   = 4'd8;
	localparam logic [3:0] EV_BTN4_UP   = 4'd9;
	localparam logic [3:0] EV_EXP_DOWN  = 4'd10;
	localparam logic [3:0] EV_EXP_UP    = 4'd11;
	localparam logic [3:0] EV_DOUBLE    = 4'd12;
	localparam logic [3:0] EV_POSITION  = 4'd13;
	localparam logic [3:0] EV_NONE      = 4'd14;

	// Frame lengths per command
	localparam logic [2:0] LEN_INIT   = 3'd4;
	localparam logic [2:0] LEN_BUTTON = 3'd5;
	localparam logic [2:0] LEN_POS    = 3'd6;
	localparam logic [2:0] LEN_DOUBLE = 3'd7;

	localparam logic [13:0] ROCKER_MIN_RESET = 14'h3FFF;

	// Job queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNTW  = $clog2(QDEPTH + 1);

	// One completed frame: reply, up to three events and the state after it
	typedef struct packed {
		logic             reply_ok;
		logic [1:0]       nev;
		logic [3:0]       ev0;
		logic [3:0]       ev1;
		logic [3:0]       ev2;
		logic [13:0]      position;
		logic [4:0]       buttons;
		logic [1:0]       present;
	} job_t;

	// Map a 16-bit button code to its event
	function automatic logic [3:0] decode_change(input logic [7:0] lo, input logic [7:0] hi);
		logic [3:0] ev;
		case ({hi, lo})
			16'h7F7D: ev = EV_BTN1_DOWN;
			16'h7E7D: ev = EV_BTN2_DOWN;
			16'h7D7D: ev = EV_BTN3_DOWN;
			16'h7C7D: ev = EV_BTN4_DOWN;
			16'h7F7F: ev = EV_BTN1_UP;
			16'h7E7F: ev = EV_BTN2_UP;
			16'h7D7F: ev = EV_BTN3_UP;
			16'h7C7F: ev = EV_BTN4_UP;
			16'h007C: ev = EV_EXP_DOWN;
			16'h007E: ev = EV_EXP_UP;
			default:  ev = EV_NONE;
		endcase
		return ev;
	endfunction

	// Apply a button event to the held-button flags
	function automatic logic [4:0] apply_button(input logic [4:0] flags, input logic [3:0] ev);
		logic [4:0] f;
		f = flags;
		case (ev)
			EV_BTN1_DOWN: f[0] = 1'b1;
			EV_BTN2_DOWN: f[1] = 1'b1;
			EV_BTN3_DOWN: f[2] = 1'b1;
			EV_BTN4_DOWN: f[3] = 1'b1;
			EV_BTN1_UP:   f[0] = 1'b0;
			EV_BTN2_UP:   f[1] = 1'b0;
			EV_BTN3_UP:   f[2] = 1'b0;
			EV_BTN4_UP:   f[3] = 1'b0;
			EV_EXP_DOWN:  f[4] = 1'b1;
			EV_EXP_UP:    f[4] = 1'b0;
			default:      f = flags;
		endcase
		return f;
	endfunction

endpackage

@@ src/pedal_frame_receiver.sv @@
// Top level of the pedal frame receiver: byte stream in, reply and event
// results out. Depends on pfr_pkg, pfr_front, pfr_queue, pfr_back.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+--------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready    | tdata[7:0] rx_byte
//  m_axis  | out | m_axis_tvalid/tready    | tdata: reply, event, position,
//          |     |                         | buttons, present; tuser kind; tlast
//
// One byte is taken per cycle while the queue has room; the frame is decoded in
// the same cycle its final byte arrives and the job enters a two-entry queue.
// Each completed frame gives one to four results, one per cycle while m_axis_tready
// is high, from the output register: four or more bytes per frame drain at full rate.
// s_axis_tready drops only while the job queue is full.
// arst_n clears frame tracking, pedal state, the queue and the output valid.
`timescale 1ns / 1ps

module pedal_frame_receiver import pfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] reply_byte, [11:8] event_code,
	                                    // [25:12] position, [30:26] buttons,
	                                    // [32:31] present, [39:33] zero
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast
);

	logic        q_full;
	logic        push;
	job_t        push_job;
	logic        head_valid;
	job_t        head_job;
	logic        pop;
	logic        r_kind;
	logic [7:0]  r_reply;
	logic [3:0]  r_event;
	logic [13:0] r_position;
	logic [4:0]  r_buttons;
	logic [1:0]  r_present;

	assign s_axis_tready = !q_full;

	pfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid && s_axis_tready),
		.byte_data  (s_axis_tdata),
		.job_push   (push),
		.job        (push_job)
	);

	pfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	pfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (head_valid),
		.job          (head_job),
		.job_pop      (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (r_kind),
		.out_reply    (r_reply),
		.out_event    (r_event),
		.out_position (r_position),
		.out_buttons  (r_buttons),
		.out_present  (r_present),
		.out_last     (m_axis_tlast)
	);

	// Pack result fields, lowest field first
	assign m_axis_tdata = {7'd0, r_present, r_buttons, r_position, r_event, r_reply};
	assign m_axis_tuser = r_kind;

endmodule

@@ src/pfr_front.sv @@
// Front end of the pedal frame receiver: assembles frames from bytes, runs
// the XOR check, decodes events and keeps pedal state. Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_front import pfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] byte_data,
	output logic       job_push,
	output job_t       job
);

	logic [7:0]  cmd_q;
	logic [2:0]  count_q;
	logic [2:0]  len_q;
	logic [7:0]  cs_q;
	logic [7:0]  data_q [1:5];
	logic [4:0]  flags_q;
	logic [1:0]  present_q;
	logic [13:0] pos_q;
	logic [13:0] min_q;

	logic        is_cmd;
	logic        room;
	logic        done;
	logic [2:0]  cmd_len;
	logic [4:0]  flags_d;
	logic [1:0]  present_d;
	logic [13:0] pos_d;
	logic [13:0] min_d;
	logic [13:0] raw_pos;
	logic [3:0]  e1;
	logic [3:0]  e2;
	logic [4:0]  flags_t;

	assign is_cmd = byte_data[7];
	assign room   = (len_q > count_q) && (count_q != 3'd7);
	assign done   = byte_valid && !is_cmd && room && ((count_q + 3'd1) == len_q);

	// Look up frame length of a command byte
	always_comb begin
		case (byte_data)
			CMD_ANNOUNCE: cmd_len = LEN_INIT;
			CMD_BUTTON:   cmd_len = LEN_BUTTON;
			CMD_POS:      cmd_len = LEN_POS;
			CMD_DOUBLE:   cmd_len = LEN_DOUBLE;
			default:      cmd_len = 3'd0;
		endcase
	end

	// Track frame position and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= 8'h00;
			count_q <= 3'd0;
			len_q   <= 3'd0;
			cs_q    <= 8'h00;
		end else if (byte_valid) begin
			if (is_cmd) begin
				cmd_q   <= byte_data;
				cs_q    <= 8'h00;
				len_q   <= cmd_len;
				count_q <= (cmd_len != 3'd0) ? 3'd1 : 3'd0;
			end else if (room && !done) begin
				cs_q    <= cs_q ^ byte_data;
				count_q <= count_q + 3'd1;
			end else begin
				len_q   <= 3'd0;
				count_q <= 3'd0;
			end
		end
	end

	// Store data bytes at their frame slot
	always_ff @(posedge clk) begin
		for (int i = 1; i <= 5; i++) begin
			if (byte_valid && !is_cmd && room && count_q == 3'(i))
				data_q[i] <= byte_data;
		end
	end

	assign raw_pos = {data_q[3][6:0], data_q[4][6:0]};
	assign e1      = decode_change(data_q[2], data_q[3]);
	assign e2      = decode_change(data_q[4], data_q[5]);
	assign flags_t = apply_button(flags_q, e1);

	// Decode the completed frame into events and next pedal state
	always_comb begin
		flags_d   = flags_q;
		present_d = present_q;
		pos_d     = pos_q;
		min_d     = min_q;
		job       = '0;
		job.reply_ok = ((cs_q ^ byte_data) == 8'h00);
		job.ev0   = EV_NONE;
		job.ev1   = EV_NONE;
		job.ev2   = EV_NONE;
		case (cmd_q)
			CMD_ANNOUNCE: begin
				if (data_q[1] == ID_FTSW) begin
					flags_d      = flags_q & 5'h10;
					present_d    = present_q | 2'b01;
					job.nev      = 2'd1;
					job.ev0      = EV_FTSW_INIT;
				end else if (data_q[1] == ID_EXP) begin
					flags_d      = flags_q & 5'h0F;
					pos_d        = 14'd0;
					present_d    = present_q | 2'b10;
					job.nev      = 2'd1;
					job.ev0      = EV_EXP_INIT;
				end
			end
			CMD_BUTTON: begin
				flags_d = flags_t;
				job.ev0 = e1;
				job.nev = (e1 != EV_NONE) ? 2'd1 : 2'd0;
			end
			CMD_DOUBLE: begin
				flags_d = apply_button(flags_t, e2);
				job.nev = 2'd3;
				job.ev0 = EV_DOUBLE;
				job.ev1 = e1;
				job.ev2 = e2;
			end
			CMD_POS: begin
				min_d   = (raw_pos < min_q) ? raw_pos : min_q;
				pos_d   = raw_pos - min_d;
				job.nev = 2'd1;
				job.ev0 = EV_POSITION;
			end
			default: begin
				job.nev = 2'd0;
			end
		endcase
		job.position = pos_d;
		job.buttons  = flags_d;
		job.present  = present_d;
	end

	assign job_push = done;

	// Commit pedal state when a frame completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= 5'd0;
			present_q <= 2'd0;
			pos_q     <= 14'd0;
			min_q     <= ROCKER_MIN_RESET;
		end else if (done) begin
			flags_q   <= flags_d;
			present_q <= present_d;
			pos_q     <= pos_d;
			min_q     <= min_d;
		end
	end

endmodule

@@ src/pfr_queue.sv @@
// Short job queue between front and back of the pedal frame receiver.
// Depends on pfr_pkg (job_t, QDEPTH).
`timescale 1ns / 1ps

module pfr_queue import pfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t            slot_q [QDEPTH];
	logic [QPTW-1:0] wr_q;
	logic [QPTW-1:0] rd_q;
	logic [QCNTW-1:0] cnt_q;

	assign full       = (cnt_q == QCNTW'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_q];

	// Write payload into the slot at the tail
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ src/pfr_back.sv @@
// Back end of the pedal frame receiver: expands each queued job into its reply and
// event results, one per cycle while out_ready is high, through an output register.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_back import pfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  out_reply,
	output logic [3:0]  out_event,
	output logic [13:0] out_position,
	output logic [4:0]  out_buttons,
	output logic [1:0]  out_present,
	output logic        out_last
);

	logic [1:0]  idx_q;
	logic        valid_q;
	logic        kind_q;
	logic [7:0]  reply_q;
	logic [3:0]  event_q;
	logic [13:0] position_q;
	logic [4:0]  buttons_q;
	logic [1:0]  present_q;
	logic        last_q;

	logic        load;
	logic        res_last;
	logic [3:0]  res_event;

	assign load     = job_valid && (!valid_q || out_ready);
	assign res_last = (idx_q == job.nev);
	assign job_pop  = load && res_last;

	// Pick the event for the current result slot
	always_comb begin
		case (idx_q)
			2'd1:    res_event = job.ev0;
			2'd2:    res_event = job.ev1;
			2'd3:    res_event = job.ev2;
			default: res_event = EV_NONE;
		endcase
	end

	// Step through the results of the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= res_last ? 2'd0 : idx_q + 2'd1;
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	// Hold the result payload until taken
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q     <= (idx_q != 2'd0);
			reply_q    <= (idx_q != 2'd0) ? 8'h00 : (job.reply_ok ? REPLY_ACK : REPLY_ERR);
			event_q    <= res_event;
			position_q <= (idx_q != 2'd0) ? job.position : 14'd0;
			buttons_q  <= (idx_q != 2'd0) ? job.buttons : 5'd0;
			present_q  <= (idx_q != 2'd0) ? job.present : 2'd0;
			last_q     <= res_last;
		end
	end

	assign out_valid    = valid_q;
	assign out_kind     = kind_q;
	assign out_reply    = reply_q;
	assign out_event    = event_q;
	assign out_position = position_q;
	assign out_buttons  = buttons_q;
	assign out_present  = present_q;
	assign out_last     = last_q;

`ifndef SYNTHESIS
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> idx_q == 2'd0)
		else $error("result index moved with no job queued");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> idx_q <= job.nev)
		else $error("result index past event count");
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> valid_q && last_q)
		else $error("job retired without a final result");
	a_reply_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && idx_q == 2'd0 |=> !kind_q)
		else $error("first result of a job is not a reply");
`endif

endmodule

@@ tb/pedal_frame_receiver_tb.sv @@
// Testbench for pedal_frame_receiver: streams pedal bus bytes in, predicts the
// reply and event results from a behavioral copy of the frame parser, checks
// every output transaction in order. Depends on pfr_pkg and the RTL under src.
`timescale 1ns / 1ps

module pedal_frame_receiver_tb;
	import pfr_pkg::*;

	// Button code bytes: low byte says press/release, high byte says which button
	localparam logic [7:0] BTN_PRESS    = 8'h7D;
	localparam logic [7:0] BTN_RELEASE  = 8'h7F;
	localparam logic [7:0] BTN_HI_FIRST = 8'h7F;
	localparam logic [7:0] BTN_HI_LAST  = 8'h7C;
	localparam logic [7:0] EXP_HI       = 8'h00;
	localparam logic [7:0] EXP_PRESS    = 8'h7C;
	localparam logic [7:0] EXP_RELEASE  = 8'h7E;

	typedef struct {
		logic        kind;
		logic [7:0]  reply;
		logic [3:0]  ev;
		logic [13:0] pos;
		logic [4:0]  btn;
		logic [1:0]  pres;
		logic        last;
	} pedal_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	logic [7:0]    rx_byte_q[$];
	pedal_result_t pending_results[$];
	int            queued_total = 0;
	int            mismatch_count = 0;
	int            tx_idle_pct = 16;
	int            rx_idle_pct = 48;
	logic          rx_taken = 1'b0;

	// Parser state mirror
	logic [7:0]  frame_store[7];
	int          frame_fill = 0;
	int          frame_size = 0;
	logic [4:0]  held_buttons = '0;
	logic [1:0]  pedals_seen = '0;
	logic [13:0] rocker_pos = '0;
	logic [13:0] rocker_floor = ROCKER_MIN_RESET;

	pedal_frame_receiver u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("pedal_frame_receiver_tb: FAIL");
		$finish;
	end

	function automatic int frame_len(input logic [7:0] cmd);
		case (cmd)
			CMD_ANNOUNCE: return LEN_INIT;
			CMD_BUTTON:   return LEN_BUTTON;
			CMD_POS:      return LEN_POS;
			CMD_DOUBLE:   return LEN_DOUBLE;
			default:      return 0;
		endcase
	endfunction

	// Map a two-byte button code to its event, or none
	function automatic logic [3:0] button_event(input logic [7:0] lo, input logic [7:0] hi);
		if (hi <= BTN_HI_FIRST && hi >= BTN_HI_LAST && lo == BTN_PRESS)
			return EV_BTN1_DOWN + 4'(BTN_HI_FIRST - hi);
		if (hi <= BTN_HI_FIRST && hi >= BTN_HI_LAST && lo == BTN_RELEASE)
			return EV_BTN1_UP + 4'(BTN_HI_FIRST - hi);
		if (hi == EXP_HI && lo == EXP_PRESS)
			return EV_EXP_DOWN;
		if (hi == EXP_HI && lo == EXP_RELEASE)
			return EV_EXP_UP;
		return EV_NONE;
	endfunction

	function automatic logic [4:0] update_buttons(input logic [4:0] flags, input logic [3:0] ev);
		if (ev >= EV_BTN1_DOWN && ev <= EV_BTN4_DOWN)
			return flags | (5'b1 << (ev - EV_BTN1_DOWN));
		if (ev >= EV_BTN1_UP && ev <= EV_BTN4_UP)
			return flags & ~(5'b1 << (ev - EV_BTN1_UP));
		if (ev == EV_EXP_DOWN)
			return flags | 5'b10000;
		if (ev == EV_EXP_UP)
			return flags & 5'b01111;
		return flags;
	endfunction

	// Advance the parser mirror by one byte and queue the results it causes
	task automatic predict_rx_byte(input logic [7:0] b);
		logic [7:0]    sum;
		logic [3:0]    evs[3];
		logic [3:0]    e1;
		logic [3:0]    e2;
		logic [13:0]   pos;
		int            nev;
		pedal_result_t r;
		nev = 0;
		sum = 8'h00;
		if (b[7]) begin
			frame_store[0] = b;
			frame_size = frame_len(b);
			frame_fill = (frame_size != 0) ? 1 : 0;
		end else if (frame_size > frame_fill && frame_fill < 7) begin
			frame_store[frame_fill] = b;
			frame_fill++;
		end else begin
			frame_size = 0;
			frame_fill = 0;
		end
		if (frame_fill == 0 || frame_fill != frame_size)
			return;
		for (int i = 1; i < frame_fill; i++)
			sum ^= frame_store[i];
		frame_fill = 0;
		frame_size = 0;

		case (frame_store[0])
			CMD_ANNOUNCE: begin
				if (frame_store[1] == ID_FTSW) begin
					held_buttons &= 5'b10000;
					pedals_seen |= 2'b01;
					evs[0] = EV_FTSW_INIT;
					nev = 1;
				end else if (frame_store[1] == ID_EXP) begin
					held_buttons &= 5'b01111;
					rocker_pos = '0;
					pedals_seen |= 2'b10;
					evs[0] = EV_EXP_INIT;
					nev = 1;
				end
			end
			CMD_BUTTON: begin
				e1 = button_event(frame_store[2], frame_store[3]);
				held_buttons = update_buttons(held_buttons, e1);
				if (e1 != EV_NONE) begin
					evs[0] = e1;
					nev = 1;
				end
			end
			CMD_DOUBLE: begin
				e1 = button_event(frame_store[2], frame_store[3]);
				e2 = button_event(frame_store[4], frame_store[5]);
				held_buttons = update_buttons(update_buttons(held_buttons, e1), e2);
				evs[0] = EV_DOUBLE;
				evs[1] = e1;
				evs[2] = e2;
				nev = 3;
			end
			default: begin
				pos = {frame_store[3][6:0], frame_store[4][6:0]};
				if (pos < rocker_floor)
					rocker_floor = pos;
				rocker_pos = pos - rocker_floor;
				evs[0] = EV_POSITION;
				nev = 1;
			end
		endcase

		r = '{kind: 1'b0, reply: (sum == 8'h00) ? REPLY_ACK : REPLY_ERR, ev: EV_NONE,
			pos: '0, btn: '0, pres: '0, last: 1'b0};
		pending_results.push_back(r);
		for (int i = 0; i < nev; i++) begin
			r = '{kind: 1'b1, reply: 8'h00, ev: evs[i], pos: rocker_pos,
				btn: held_buttons, pres: pedals_seen, last: 1'b0};
			pending_results.push_back(r);
		end
		pending_results[pending_results.size() - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Drive the byte stream and the result backpressure at the falling edge
	always @(negedge clk) begin
		logic       nxt_valid;
		logic [7:0] nxt_data;
		nxt_valid = s_axis_tvalid;
		nxt_data = s_axis_tdata;
		if (s_axis_tvalid && rx_taken)
			nxt_valid = 1'b0;
		if (arst_n && !nxt_valid && rx_byte_q.size() != 0
				&& $urandom_range(0, 99) >= tx_idle_pct) begin
			nxt_data = rx_byte_q.pop_front();
			nxt_valid = 1'b1;
		end
		s_axis_tvalid <= nxt_valid;
		s_axis_tdata <= nxt_data;
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Predict on each accepted byte, check each accepted result
	always @(posedge clk) begin
		pedal_result_t want;
		if (!arst_n) begin
			rx_taken = 1'b0;
		end else begin
			rx_taken = s_axis_tvalid && s_axis_tready;
			if (rx_taken)
				predict_rx_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result tdata", m_axis_tdata, '0);
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tuser !== want.kind)
						report_mismatch("kind", m_axis_tuser, want.kind);
					if (m_axis_tdata[7:0] !== want.reply)
						report_mismatch("reply_byte", m_axis_tdata[7:0], want.reply);
					if (m_axis_tdata[11:8] !== want.ev)
						report_mismatch("event_code", m_axis_tdata[11:8], want.ev);
					if (m_axis_tdata[25:12] !== want.pos)
						report_mismatch("position", m_axis_tdata[25:12], want.pos);
					if (m_axis_tdata[30:26] !== want.btn)
						report_mismatch("buttons", m_axis_tdata[30:26], want.btn);
					if (m_axis_tdata[32:31] !== want.pres)
						report_mismatch("present", m_axis_tdata[32:31], want.pres);
					if (m_axis_tdata[39:33] !== 7'd0)
						report_mismatch("tdata padding", m_axis_tdata[39:33], 0);
					if (m_axis_tlast !== want.last)
						report_mismatch("last", m_axis_tlast, want.last);
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_byte_q.push_back(b);
		queued_total++;
	endtask

	// Queue a command, its body bytes and a closing byte that zeroes the XOR unless corrupt
	task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] b1, b2, b3, b4, b5,
			input bit corrupt);
		logic [7:0] body[5];
		logic [7:0] sum;
		body = '{b1, b2, b3, b4, b5};
		sum = 8'h00;
		push_byte(cmd);
		for (int i = 0; i < frame_len(cmd) - 2; i++) begin
			push_byte(body[i] & 8'h7F);
			sum ^= body[i] & 8'h7F;
		end
		if (corrupt)
			sum ^= 8'($urandom_range(1, 127));
		push_byte(sum);
	endtask

	function automatic logic [7:0] rand7();
		return 8'($urandom_range(0, 127));
	endfunction

	// Mostly valid button codes, {hi, lo}
	function automatic logic [15:0] pick_code();
		int k;
		k = $urandom_range(0, 13);
		if (k < 4)
			return {BTN_HI_FIRST - 8'(k), BTN_PRESS};
		if (k < 8)
			return {BTN_HI_FIRST - 8'(k - 4), BTN_RELEASE};
		if (k == 8)
			return {EXP_HI, EXP_PRESS};
		if (k == 9)
			return {EXP_HI, EXP_RELEASE};
		return {rand7(), rand7()};
	endfunction

	function automatic logic [7:0] pos_byte();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'h7F;
			default: return rand7();
		endcase
	endfunction

	// Mostly well-formed frames, some cut short, some with extra data, some noise
	task automatic queue_random(input int nbytes);
		int          target;
		int          sel;
		logic [7:0]  cmd;
		logic [7:0]  b[5];
		logic [15:0] c1;
		logic [15:0] c2;
		target = queued_total + nbytes;
		while (queued_total < target) begin
			sel = $urandom_range(0, 99);
			c1 = pick_code();
			c2 = pick_code();
			b = '{rand7(), rand7(), rand7(), rand7(), rand7()};
			case ($urandom_range(0, 3))
				0: begin
					cmd = CMD_ANNOUNCE;
					case ($urandom_range(0, 4))
						0, 1:    b[0] = ID_FTSW;
						2, 3:    b[0] = ID_EXP;
						default: b[0] = rand7();
					endcase
				end
				1: begin
					cmd = CMD_BUTTON;
					{b[2], b[1]} = c1;
				end
				2: begin
					cmd = CMD_POS;
					b[2] = pos_byte();
					b[3] = pos_byte();
				end
				default: begin
					cmd = CMD_DOUBLE;
					{b[2], b[1]} = c1;
					{b[4], b[3]} = c2;
				end
			endcase
			if (sel < 78) begin
				queue_frame(cmd, b[0], b[1], b[2], b[3], b[4], $urandom_range(0, 6) == 0);
			end else if (sel < 86) begin
				push_byte(cmd);
				repeat ($urandom_range(0, frame_len(cmd) - 2))
					push_byte(rand7());
			end else if (sel < 92) begin
				queue_frame(cmd, b[0], b[1], b[2], b[3], b[4], 1'b0);
				push_byte(rand7());
			end else begin
				repeat ($urandom_range(1, 3))
					push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic drain_stimulus();
		while (rx_byte_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
	endtask

	initial begin
		wait (arst_n);

		// Directed: stray data byte with no frame open, unknown command,
		// footswitch init, expression init with a bad check, extreme
		// position, double button with one unmatched code
		push_byte(8'h00);
		push_byte(8'hFF);
		queue_frame(CMD_ANNOUNCE, ID_FTSW, 8'h7F, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_frame(CMD_ANNOUNCE, ID_EXP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_frame(CMD_POS, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h00, 1'b0);
		queue_frame(CMD_DOUBLE, 8'h7F, BTN_PRESS, BTN_HI_FIRST, 8'h00, 8'h00, 1'b0);

		queue_random(100);
		drain_stimulus();
		tx_idle_pct = 48;
		rx_idle_pct = 16;
		queue_random(110);
		drain_stimulus();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random(110);
		drain_stimulus();

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("pedal_frame_receiver_tb: PASS");
		else
			$display("pedal_frame_receiver_tb: FAIL");
		$finish;
	end

endmodule
